// ===== sv/mttn_pkg.sv =====
package mttn_pkg;

  localparam int TICK_W = 64;
  localparam int HZ_W   = 40;
  localparam int NS_W   = 64;
  localparam int PROD_W = 62;
  // ticks * 1e9 fits in 94 bits
  localparam int NUM_W  = 94;
  localparam int CNT_W  = 7;

  localparam logic [29:0]      NS_PER_SEC = 30'd1000000000;
  localparam logic [CNT_W-1:0] DIV_LAST   = 7'(NUM_W - 1);

  localparam logic [1:0] CFG_ENABLE  = 2'd0;
  localparam logic [1:0] CFG_IS_64   = 2'd1;
  localparam logic [1:0] CFG_TICK_HZ = 2'd2;

  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_MUL0 = 3'd1;
  localparam logic [2:0] ST_MUL1 = 3'd2;
  localparam logic [2:0] ST_DIV  = 3'd3;
  localparam logic [2:0] ST_FIN  = 3'd4;

endpackage

// ===== sv/monotonic_tick_to_ns_clock.sv =====
// An accepted request runs 2 multiply steps, 94 restoring-division steps
// through one 41-bit subtractor and 1 finish step (only the finish step
// when disabled or at zero rate). in_stall is high while the sequencer is
// not idle, also while a finished result waits behind a stalled output.
// Reset (rst_n low, synchronous): configuration registers read zero, wrap
// and last-time state cleared, no result pending.
module monotonic_tick_to_ns_clock
  import mttn_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              cfg_wr_en,
  input  logic [1:0]        cfg_index,
  input  logic [HZ_W-1:0]   cfg_wdata,
  input  logic              in_valid,
  output logic              in_stall,
  input  logic [TICK_W-1:0] in_counter_value,
  output logic              out_valid,
  input  logic              out_stall,
  output logic [NS_W-1:0]   out_time_ns,
  output logic [TICK_W-1:0] out_extended_ticks,
  output logic              out_saturated
);

  logic            enable_r;
  logic            is_64_r;
  logic [HZ_W-1:0] tick_hz_r;

  logic [2:0]        state_r, state_nxt;
  logic [CNT_W-1:0]  cnt_r, cnt_nxt;
  logic [31:0]       last_low_r, last_low_nxt;
  logic [31:0]       wrap_r, wrap_nxt;
  logic [NS_W-1:0]   last_time_r, last_time_nxt;
  logic [TICK_W-1:0] ticks_r, ticks_nxt;
  logic [NUM_W-1:0]  num_r, num_nxt;
  logic [HZ_W-1:0]   rem_r, rem_nxt;
  logic [NS_W-1:0]   quo_r, quo_nxt;
  logic              ovf_r, ovf_nxt;

  logic              out_valid_r, out_valid_nxt;
  logic [NS_W-1:0]   out_time_r, out_time_nxt;
  logic [TICK_W-1:0] out_ticks_r, out_ticks_nxt;
  logic              out_sat_r, out_sat_nxt;

  logic              in_acc;
  logic              out_free;
  logic [31:0]       low_word;
  logic              wrap_inc;
  logic [31:0]       wrap_ext;
  logic [31:0]       mul_a;
  logic [PROD_W-1:0] prod;
  logic [HZ_W:0]     trial;
  logic              ge;
  logic [HZ_W:0]     diff;
  logic [NS_W-1:0]   conv_ns;
  logic [NS_W-1:0]   clamp_ns;

  assign in_stall = (state_r != ST_IDLE);
  assign in_acc   = in_valid && !in_stall;
  assign out_free = !out_valid_r || !out_stall;

  // Wrap extension of the 32-bit counter
  assign low_word = in_counter_value[31:0];
  assign wrap_inc = (low_word < last_low_r);
  assign wrap_ext = wrap_r + {31'b0, wrap_inc};

  // Shared multiplier: one 32-bit half of the ticks per step
  assign mul_a = (state_r == ST_MUL0) ? ticks_r[31:0] : ticks_r[63:32];
  assign prod  = {30'b0, mul_a} * {32'b0, NS_PER_SEC};

  // Shared subtractor for the restoring division
  assign trial = {rem_r, num_r[NUM_W-1]};
  assign ge    = (trial >= {1'b0, tick_hz_r});
  assign diff  = trial - {1'b0, tick_hz_r};

  assign conv_ns  = ovf_r ? {NS_W{1'b1}} : quo_r;
  assign clamp_ns = (conv_ns < last_time_r) ? last_time_r : conv_ns;

  always_comb begin
    state_nxt     = state_r;
    cnt_nxt       = cnt_r;
    last_low_nxt  = last_low_r;
    wrap_nxt      = wrap_r;
    last_time_nxt = last_time_r;
    ticks_nxt     = ticks_r;
    num_nxt       = num_r;
    rem_nxt       = rem_r;
    quo_nxt       = quo_r;
    ovf_nxt       = ovf_r;
    out_valid_nxt = out_valid_r && out_stall;
    out_time_nxt  = out_time_r;
    out_ticks_nxt = out_ticks_r;
    out_sat_nxt   = out_sat_r;

    unique case (state_r)
      ST_IDLE: begin
        if (in_acc) begin
          quo_nxt = '0;
          ovf_nxt = 1'b0;
          rem_nxt = '0;
          cnt_nxt = '0;
          if (!enable_r) begin
            ticks_nxt = '0;
            state_nxt = ST_FIN;
          end else begin
            if (is_64_r) begin
              ticks_nxt = in_counter_value;
            end else begin
              ticks_nxt    = {wrap_ext, low_word};
              wrap_nxt     = wrap_ext;
              last_low_nxt = low_word;
            end
            // zero rate converts to zero
            state_nxt = (tick_hz_r == '0) ? ST_FIN : ST_MUL0;
          end
        end
      end
      ST_MUL0: begin
        num_nxt   = {32'b0, prod};
        state_nxt = ST_MUL1;
      end
      ST_MUL1: begin
        num_nxt   = num_r + {prod, 32'b0};
        state_nxt = ST_DIV;
      end
      ST_DIV: begin
        rem_nxt = ge ? diff[HZ_W-1:0] : trial[HZ_W-1:0];
        // quotient bits above 63 mean the result does not fit
        ovf_nxt = ovf_r | quo_r[NS_W-1];
        quo_nxt = {quo_r[NS_W-2:0], ge};
        num_nxt = {num_r[NUM_W-2:0], 1'b0};
        cnt_nxt = cnt_r + 7'd1;
        if (cnt_r == DIV_LAST) begin
          state_nxt = ST_FIN;
        end
      end
      ST_FIN: begin
        // hold until the output register is free
        if (out_free) begin
          out_valid_nxt = 1'b1;
          out_time_nxt  = clamp_ns;
          out_ticks_nxt = ticks_r;
          out_sat_nxt   = ovf_r;
          last_time_nxt = clamp_ns;
          state_nxt     = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      enable_r    <= 1'b0;
      is_64_r     <= 1'b0;
      tick_hz_r   <= '0;
      state_r     <= ST_IDLE;
      cnt_r       <= '0;
      last_low_r  <= '0;
      wrap_r      <= '0;
      last_time_r <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_wr_en) begin
        unique case (cfg_index)
          CFG_ENABLE:  enable_r  <= cfg_wdata[0];
          CFG_IS_64:   is_64_r   <= cfg_wdata[0];
          CFG_TICK_HZ: tick_hz_r <= cfg_wdata;
          default: ;
        endcase
      end
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      last_low_r  <= last_low_nxt;
      wrap_r      <= wrap_nxt;
      last_time_r <= last_time_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    ticks_r     <= ticks_nxt;
    num_r       <= num_nxt;
    rem_r       <= rem_nxt;
    quo_r       <= quo_nxt;
    ovf_r       <= ovf_nxt;
    out_time_r  <= out_time_nxt;
    out_ticks_r <= out_ticks_nxt;
    out_sat_r   <= out_sat_nxt;
  end

  assign out_valid          = out_valid_r;
  assign out_time_ns        = out_time_r;
  assign out_extended_ticks = out_ticks_r;
  assign out_saturated      = out_sat_r;

  a_acc_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc |=> state_r != ST_IDLE)
    else $error("accepted request did not start the sequencer");

  a_sat_max: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_sat_r |-> out_time_r == {NS_W{1'b1}})
    else $error("saturated result is not the maximum time");

  a_last_time: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> out_time_r == last_time_r)
    else $error("pending result differs from last given time");

  a_div_count: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_DIV |-> cnt_r <= DIV_LAST)
    else $error("division step count out of range");

endmodule

// ===== verif/tick_clock_checker.sv =====
module tick_clock_checker
  import mttn_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              cfg_wr_en,
  input  logic [1:0]        cfg_index,
  input  logic [HZ_W-1:0]   cfg_wdata,
  input  logic              in_valid,
  input  logic              in_stall,
  input  logic [TICK_W-1:0] in_counter_value,
  input  logic              out_valid,
  input  logic              out_stall,
  input  logic [NS_W-1:0]   out_time_ns,
  input  logic [TICK_W-1:0] out_extended_ticks,
  input  logic              out_saturated,
  output int                fail_count,
  output int                pending,
  output int                checked,
  output int                saturations
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic [NS_W-1:0]   time_ns;
    logic [TICK_W-1:0] ticks;
    logic              saturated;
  } clock_reading_t;

  localparam logic [127:0] NS_PER_SECOND = 128'd1_000_000_000;

  logic              enabled;
  logic              wide_counter;
  logic [HZ_W-1:0]   rate_hz;
  logic [31:0]       prev_low;
  logic [31:0]       wraps;
  logic [NS_W-1:0]   latest_ns;
  clock_reading_t    expected_times[$];
  int                fails = 0;
  int                n_checked = 0;
  int                n_sat = 0;

  // Extend the read, convert it exactly at full width, then clamp to the last time out.
  function automatic clock_reading_t convert_reading(input logic [TICK_W-1:0] raw);
    clock_reading_t r;
    logic [127:0]   scaled;
    logic [127:0]   quotient;
    r = '0;
    if (enabled) begin
      if (wide_counter) begin
        r.ticks = raw;
      end else begin
        if (raw[31:0] < prev_low) wraps = wraps + 32'd1;
        prev_low = raw[31:0];
        r.ticks = {wraps, raw[31:0]};
      end
      if (rate_hz != '0) begin
        scaled = 128'(r.ticks) * NS_PER_SECOND;
        quotient = scaled / 128'(rate_hz);
        if (quotient[127:64] != '0) begin
          r.saturated = 1'b1;
          r.time_ns = '1;
        end else begin
          r.time_ns = quotient[63:0];
        end
      end
    end
    if (r.time_ns < latest_ns) r.time_ns = latest_ns;
    else latest_ns = r.time_ns;
    return r;
  endfunction

  task automatic check_field(input string field, input logic [63:0] want,
                             input logic [63:0] got);
    if (got !== want) begin
      fails++;
      $display("%0t: %s mismatch: expected %0d, actual %0d", $time, field, want, got);
    end
  endtask

  always @(posedge clk) begin
    clock_reading_t head;
    if (!rst_n) begin
      enabled = 1'b0;
      wide_counter = 1'b0;
      rate_hz = '0;
      prev_low = '0;
      wraps = '0;
      latest_ns = '0;
      expected_times.delete();
    end else begin
      if (cfg_wr_en) begin
        case (cfg_index)
          CFG_ENABLE:  enabled = cfg_wdata[0];
          CFG_IS_64:   wide_counter = cfg_wdata[0];
          CFG_TICK_HZ: rate_hz = cfg_wdata;
          default: ;
        endcase
      end
      if (in_valid && !in_stall) expected_times.push_back(convert_reading(in_counter_value));
      if (out_valid && !out_stall) begin
        if (expected_times.size() == 0) begin
          fails++;
          $display("%0t: result with nothing expected: time_ns %0d, ticks %0d, saturated %0d",
                   $time, out_time_ns, out_extended_ticks, out_saturated);
        end else begin
          head = expected_times.pop_front();
          n_checked++;
          if (head.saturated) n_sat++;
          check_field("time_ns", head.time_ns, out_time_ns);
          check_field("extended_ticks", head.ticks, out_extended_ticks);
          check_field("saturated", 64'(head.saturated), 64'(out_saturated));
        end
      end
    end
    fail_count <= fails;
    pending <= expected_times.size();
    checked <= n_checked;
    saturations <= n_sat;
  end

endmodule

// ===== verif/testbench.sv =====
module testbench;
  timeunit 1ns;
  timeprecision 1ps;
  import mttn_pkg::*;

  localparam int QUIET_LIMIT = 1000;
  localparam int TAIL_CYCLES = 200;
  localparam logic [HZ_W-1:0] HZ_MAX  = '1;
  localparam logic [HZ_W-1:0] ONE_GHZ = 40'd1_000_000_000;
  localparam logic [HZ_W-1:0] ONE_THZ = 40'd1_000_000_000_000;

  logic              clk = 1'b0;
  logic              rst_n = 1'b0;
  logic              cfg_wr_en = 1'b0;
  logic [1:0]        cfg_index = CFG_ENABLE;
  logic [HZ_W-1:0]   cfg_wdata = '0;
  logic              in_valid = 1'b0;
  logic              in_stall;
  logic [TICK_W-1:0] in_counter_value = '0;
  logic              out_valid;
  logic              out_stall = 1'b0;
  logic [NS_W-1:0]   out_time_ns;
  logic [TICK_W-1:0] out_extended_ticks;
  logic              out_saturated;

  int fail_count;
  int pending_results;
  int checked_results;
  int saturated_results;

  bit          idle_on = 1'b1;
  int          stall_left = 0;
  int          quiet_cycles = 0;
  int          settings_written = 0;
  logic [31:0] low_word = '0;

  monotonic_tick_to_ns_clock dut (
    .clk                (clk),
    .rst_n              (rst_n),
    .cfg_wr_en          (cfg_wr_en),
    .cfg_index          (cfg_index),
    .cfg_wdata          (cfg_wdata),
    .in_valid           (in_valid),
    .in_stall           (in_stall),
    .in_counter_value   (in_counter_value),
    .out_valid          (out_valid),
    .out_stall          (out_stall),
    .out_time_ns        (out_time_ns),
    .out_extended_ticks (out_extended_ticks),
    .out_saturated      (out_saturated)
  );

  tick_clock_checker clock_check (
    .clk                (clk),
    .rst_n              (rst_n),
    .cfg_wr_en          (cfg_wr_en),
    .cfg_index          (cfg_index),
    .cfg_wdata          (cfg_wdata),
    .in_valid           (in_valid),
    .in_stall           (in_stall),
    .in_counter_value   (in_counter_value),
    .out_valid          (out_valid),
    .out_stall          (out_stall),
    .out_time_ns        (out_time_ns),
    .out_extended_ticks (out_extended_ticks),
    .out_saturated      (out_saturated),
    .fail_count         (fail_count),
    .pending            (pending_results),
    .checked            (checked_results),
    .saturations        (saturated_results)
  );

  initial begin
    forever #10 clk = ~clk;
  end

  // Hold each result off for a random number of its valid cycles.
  always @(posedge clk) begin
    if (!rst_n) begin
      stall_left = 0;
      out_stall <= 1'b0;
    end else begin
      if (out_valid && !out_stall) stall_left = idle_on ? $urandom_range(0, 7) : 0;
      else if (out_valid && stall_left != 0) stall_left--;
      out_stall <= (stall_left != 0);
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles == QUIET_LIMIT) begin
      $display("%0t: no request or result moved for %0d cycles", $time, QUIET_LIMIT);
      $display("Some tests failed");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // Write all three registers back to back; the 1-bit ones get junk above bit 0.
  task automatic program_clock(input logic en, input logic wide, input logic [HZ_W-1:0] hz);
    idle_on = ($urandom_range(0, 3) != 0);
    settings_written++;
    cfg_wr_en <= 1'b1;
    cfg_index <= CFG_ENABLE;
    cfg_wdata <= {39'({$urandom, $urandom}), en};
    @(posedge clk);
    cfg_index <= CFG_IS_64;
    cfg_wdata <= {39'({$urandom, $urandom}), wide};
    @(posedge clk);
    cfg_index <= CFG_TICK_HZ;
    cfg_wdata <= hz;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
  endtask

  task automatic send_reading(input logic [TICK_W-1:0] value);
    int gap;
    gap = idle_on ? $urandom_range(0, 7) : 0;
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_counter_value <= value;
    @(posedge clk);
    while (in_stall) @(posedge clk);
  endtask

  // Drop valid and wait until every request has its result back.
  task automatic settle();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending_results != 0) @(posedge clk);
  endtask

  // Counter reads that mostly advance, with natural and forced wraps.
  task automatic run_counting_phase(input logic [HZ_W-1:0] hz, input int count);
    program_clock(1'b1, 1'b0, hz);
    for (int k = 0; k < count; k++) begin
      if ($urandom_range(0, 15) == 0) low_word = $urandom_range(0, low_word);
      else low_word = low_word + ($urandom >> $urandom_range(4, 31));
      send_reading({$urandom, low_word});
    end
    settle();
  endtask

  // Full 64-bit reads near hz << shift_by, so times land near 2^shift_by seconds.
  task automatic run_wide_phase(input logic [HZ_W-1:0] hz, input int shift_by, input int count);
    logic [63:0] ticks;
    program_clock(1'b1, 1'b1, hz);
    ticks = 64'(hz) << shift_by;
    for (int k = 0; k < count; k++) begin
      ticks = ticks + ({$urandom, $urandom} % (64'(hz) * 64'd8 + 64'd1));
      send_reading(ticks);
    end
    settle();
  endtask

  task automatic run_noise_phase(input logic en, input logic wide, input logic [HZ_W-1:0] hz,
                                 input int count);
    program_clock(en, wide, hz);
    for (int k = 0; k < count; k++) send_reading({$urandom, $urandom} >> $urandom_range(0, 63));
    settle();
  endtask

  initial begin
    logic [HZ_W-1:0] hz;
    int              band;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // out of reset the clock is disabled at zero rate
    send_reading('1);
    send_reading('0);
    settle();
    // zero rate still extends ticks
    program_clock(1'b1, 1'b0, '0);
    send_reading({32'hA5A5_5A5A, 32'hFFFF_FFFF});
    send_reading(64'd5);
    settle();
    // rate above 1 THz; an equal low word is not a wrap
    program_clock(1'b1, 1'b0, HZ_MAX);
    send_reading(64'd5);
    send_reading(64'd6);
    send_reading(64'h0000_0000_8000_0000);
    send_reading({32'hFFFF_FFFF, 32'h7FFF_FFFF});
    settle();
    // disabled: a lower word must not count a wrap
    program_clock(1'b0, 1'b0, HZ_MAX);
    send_reading(64'd0);
    settle();
    // 64-bit mode leaves the wrap state alone
    program_clock(1'b1, 1'b1, ONE_THZ);
    send_reading(64'h0000_0000_8000_0000);
    send_reading(64'd1);
    settle();
    program_clock(1'b1, 1'b0, ONE_THZ);
    send_reading(64'h0000_0000_8000_0000);
    send_reading(64'd1);
    settle();

    // Lower the rate phase by phase so converted times keep climbing.
    for (int p = 0; p < 10; p++) begin
      band = 40 - 3 * p;
      hz = HZ_W'((64'd1 << (band - 1)) | ({$urandom, $urandom} & ((64'd1 << (band - 1)) - 1)));
      run_counting_phase(hz, 60);
      if (p == 3) run_noise_phase(1'b0, 1'($urandom_range(0, 1)), hz, 20);
      if (p == 6) run_noise_phase(1'b1, 1'b0, '0, 20);
    end

    for (int p = 0; p < 6; p++) begin
      if (p == 0) hz = ONE_GHZ;
      else if (p == 1) hz = 40'd3;
      else hz = HZ_W'($urandom_range(1, 1 << 30));
      run_wide_phase(hz, 27 + p, 40);
    end

    // Saturation pins the time at its top, so it comes last.
    program_clock(1'b1, 1'b1, 40'd1);
    send_reading('1);
    for (int k = 0; k < 3; k++) send_reading({1'b1, 63'({$urandom, $urandom})});
    settle();
    program_clock(1'b1, 1'b0, 40'd1);
    for (int k = 0; k < 4; k++) begin
      low_word = low_word + ($urandom >> 3);
      send_reading({$urandom, low_word});
    end
    settle();
    program_clock(1'b1, 1'b1, HZ_MAX);
    send_reading('1);
    send_reading({$urandom, $urandom});
    settle();

    for (int p = 0; p < 3; p++) begin
      case ($urandom_range(0, 2))
        0:       hz = '0;
        1:       hz = HZ_W'({$urandom, $urandom});
        default: hz = HZ_W'($urandom_range(1, 1000));
      endcase
      run_noise_phase(1'($urandom_range(0, 3) != 0), 1'($urandom_range(0, 1)), hz, 20);
    end

    repeat (TAIL_CYCLES) @(posedge clk);
    @(negedge clk);
    $display("Run checked %0d time reads over %0d register settings in both counter modes,",
             checked_results, settings_written);
    $display("covering wraps, disabled and zero-rate reads, and %0d saturated conversions.",
             saturated_results);
    if (fail_count == 0 && pending_results == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
